@@ design/dwpi_pkg.sv @@
package dwpi_pkg;

  // Field and datapath widths
  localparam int unsigned CNT_W    = 16;  // encoder count, target, gains, period
  localparam int unsigned MAXD_W   = 10;  // max_drive register
  localparam int unsigned ERR_W    = 25;  // target - (count << 8), signed .8
  localparam int unsigned INTEG_W  = 24;  // integral, signed Q8.16
  localparam int unsigned PROD_W   = 41;  // 25-bit signed times 16-bit unsigned
  localparam int unsigned INC_W    = PROD_W - 8;
  localparam int unsigned ACC_W    = 34;  // integral plus increment before clamp
  localparam int unsigned SUM_W    = 42;  // proportional plus integral term
  localparam int unsigned HI_W     = SUM_W - 16;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned MUL_STEPS = CNT_W;
  localparam int unsigned STEP_W   = $clog2(MUL_STEPS);

  // Integral clamp (35.0 in Q8.16) and ready window (5.0 in .8)
  localparam logic signed [ACC_W-1:0] INTEG_LIMIT = ACC_W'(35 * 65536);
  localparam logic signed [ERR_W-1:0] READY_LIMIT = ERR_W'(5 * 256);

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_TOP_TARGET    = 3'd0;
  localparam logic [IDX_W-1:0] REG_BOTTOM_TARGET = 3'd1;
  localparam logic [IDX_W-1:0] REG_PROP_GAIN     = 3'd2;
  localparam logic [IDX_W-1:0] REG_INTEG_GAIN    = 3'd3;
  localparam logic [IDX_W-1:0] REG_PERIOD_FRAC   = 3'd4;
  localparam logic [IDX_W-1:0] REG_MAX_DRIVE     = 3'd5;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_PF,
    ST_INTEG,
    ST_MUL_KP,
    ST_PROP,
    ST_MUL_KI,
    ST_EMIT
  } dwpi_state_e;

  // Per-cycle commands from the sequencer to both wheel datapaths
  typedef struct packed {
    logic load_err;   // form error, start error * period_fraction
    logic mul_step;   // one shift-add step of the multiplier
    logic upd_integ;  // clamp and store integral, start error * prop_gain
    logic save_prop;  // keep proportional term, start integral * integ_gain
  } dwpi_ctrl_t;

endpackage

@@ design/dwpi_chan.sv @@
module dwpi_chan
  import dwpi_pkg::*;
#(
  parameter int unsigned DRIVE_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dwpi_ctrl_t            ctrl_i,
  input  logic [CNT_W-1:0]      target_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [CNT_W-1:0]      period_frac_i,
  input  logic [CNT_W-1:0]      prop_gain_i,
  input  logic [CNT_W-1:0]      integ_gain_i,
  input  logic [DRIVE_BITS-1:0] lim_i,
  output logic [DRIVE_BITS-1:0] drive_o,
  output logic                  small_o
);

  logic signed [ERR_W-1:0]   err_d, err_q;
  logic        [PROD_W-1:0]  mcand_q, prod_q, prop_q;
  logic        [CNT_W-1:0]   mplier_q;
  logic signed [INTEG_W-1:0] integ_q, integ_d;
  logic signed [INC_W-1:0]   inc;
  logic signed [ACC_W-1:0]   acc;
  logic signed [SUM_W-1:0]   sum;
  logic        [HI_W-1:0]    hi;

  // Speed error in .8: target minus count shifted up by eight
  assign err_d = $signed({{(ERR_W-CNT_W){1'b0}}, target_i})
               - $signed({1'b0, count_i, 8'b0});

  // Floor the error * period product to .16 and add to the integral
  assign inc = $signed(prod_q[PROD_W-1:8]);
  assign acc = $signed({{(ACC_W-INTEG_W){integ_q[INTEG_W-1]}}, integ_q})
             + $signed({{(ACC_W-INC_W){inc[INC_W-1]}}, inc});

  // Clamp to +/-35
  always_comb begin
    if (acc > INTEG_LIMIT) begin
      integ_d = INTEG_LIMIT[INTEG_W-1:0];
    end else if (acc < -INTEG_LIMIT) begin
      integ_d = INTEG_W'(-INTEG_LIMIT);
    end else begin
      integ_d = acc[INTEG_W-1:0];
    end
  end

  // Integral state, held unless an enabled item updates it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (ctrl_i.upd_integ) begin
      integ_q <= integ_d;
    end
  end

  // Shift-add multiplier: one multiplier bit per cycle, LSB first
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_err) begin
      err_q    <= err_d;
      mcand_q  <= {{(PROD_W-ERR_W){err_d[ERR_W-1]}}, err_d};
      mplier_q <= period_frac_i;
      prod_q   <= '0;
    end else if (ctrl_i.upd_integ) begin
      mcand_q  <= {{(PROD_W-ERR_W){err_q[ERR_W-1]}}, err_q};
      mplier_q <= prop_gain_i;
      prod_q   <= '0;
    end else if (ctrl_i.save_prop) begin
      prop_q   <= prod_q;
      mcand_q  <= {{(PROD_W-INTEG_W){integ_q[INTEG_W-1]}}, integ_q};
      mplier_q <= integ_gain_i;
      prod_q   <= '0;
    end else if (ctrl_i.mul_step) begin
      if (mplier_q[0]) begin
        prod_q <= prod_q + mcand_q;
      end
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  // Drive: proportional term plus floored integral term, then clamp
  assign sum = $signed({prop_q[PROD_W-1], prop_q})
             + $signed({{(SUM_W-INC_W){prod_q[PROD_W-1]}}, prod_q[PROD_W-1:8]});
  assign hi  = sum[SUM_W-1:16];

  always_comb begin
    if (err_q[ERR_W-1] || sum[SUM_W-1] || (sum == '0)) begin
      drive_o = '0;
    end else if (hi > HI_W'(lim_i)) begin
      drive_o = lim_i;
    end else begin
      drive_o = hi[DRIVE_BITS-1:0];
    end
  end

  assign small_o = (err_q < READY_LIMIT) && (err_q > -READY_LIMIT);

endmodule

@@ design/dual_wheel_pi_speed_regulator_top.sv @@
// Two-wheel PI speed regulator. Each request on the slave stream is one control
// period carrying both encoder counts and an enable bit; each produces exactly one
// result with both motor drives and a ready flag (both speed errors under five
// counts). Per wheel the error (target minus count, .8) times the period fraction
// is floored and added to an integral clamped to +/-35 (Q8.16); the drive is
// error*prop_gain plus floored integral*integ_gain, taken to an integer, forced to
// zero on negative error or a non-positive sum and limited to max_drive and the
// DRIVE_BITS range. A disabled request returns zero drives and ready low and
// leaves both integrals untouched. An enabled request runs three 16-step
// shift-add multiplications per wheel, one multiplier bit per cycle, with the two
// wheels running side by side. A new request is accepted only after the previous
// one has finished. The result sits in an output register, so the next request
// is accepted while it waits. Configuration is written through
// cfg_we_i/cfg_idx_i/cfg_wdata_i; the user must do so only while the block is
// idle, which the block itself does not enforce. Indexes above 5 are ignored.
module dual_wheel_pi_speed_regulator_top
  import dwpi_pkg::*;
#(
  parameter int unsigned DRIVE_BITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port
  input  logic                cfg_we_i,
  input  logic [IDX_W-1:0]    cfg_idx_i,
  input  logic [CNT_W-1:0]    cfg_wdata_i,
  // Input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [39:0]         s_axis_tdata,  // top_count[15:0], bottom_count[31:16],
                                             // enable[32], zero fill
  // Result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [((2*DRIVE_BITS+1+7)/8)*8-1:0] m_axis_tdata  // top_drive, bottom_drive,
                                                            // ready_res, zero fill
);

  localparam int unsigned OUT_W = ((2*DRIVE_BITS+1+7)/8)*8;
  localparam logic [CNT_W-1:0] DRIVE_CAP = CNT_W'((1 << DRIVE_BITS) - 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MUL_STEPS - 1);

  dwpi_state_e state_q, state_d;
  dwpi_ctrl_t  ctrl;
  logic [STEP_W-1:0] step_q, step_d;

  logic [CNT_W-1:0]  top_target_q, bot_target_q, prop_gain_q, integ_gain_q, period_q;
  logic [MAXD_W-1:0] max_drive_q;
  logic [CNT_W-1:0]  lim16;
  logic [DRIVE_BITS-1:0] lim;

  logic [CNT_W-1:0] top_cnt_q, bot_cnt_q;
  logic             en_q;

  logic [DRIVE_BITS-1:0] top_drive, bot_drive;
  logic                  top_small, bot_small;

  logic             out_valid_q;
  logic [OUT_W-1:0] out_data_q;
  logic             out_load;
  logic             in_acc;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_target_q <= '0;
      bot_target_q <= '0;
      prop_gain_q  <= CNT_W'(256);
      integ_gain_q <= '0;
      period_q     <= CNT_W'(655);
      max_drive_q  <= MAXD_W'(1023);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TOP_TARGET:    top_target_q <= cfg_wdata_i;
        REG_BOTTOM_TARGET: bot_target_q <= cfg_wdata_i;
        REG_PROP_GAIN:     prop_gain_q  <= cfg_wdata_i;
        REG_INTEG_GAIN:    integ_gain_q <= cfg_wdata_i;
        REG_PERIOD_FRAC:   period_q     <= cfg_wdata_i;
        REG_MAX_DRIVE:     max_drive_q  <= cfg_wdata_i[MAXD_W-1:0];
        default: ;
      endcase
    end
  end

  // Drive limit: the smaller of max_drive and the drive width
  assign lim16 = (CNT_W'(max_drive_q) < DRIVE_CAP) ? CNT_W'(max_drive_q) : DRIVE_CAP;
  assign lim   = lim16[DRIVE_BITS-1:0];

  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      top_cnt_q <= s_axis_tdata[15:0];
      bot_cnt_q <= s_axis_tdata[31:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
    end else if (in_acc) begin
      en_q <= s_axis_tdata[32];
    end
  end

  // Sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d       = state_q;
    step_d        = '0;
    ctrl          = '0;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = s_axis_tdata[32] ? ST_ERR : ST_EMIT;
        end
      end
      ST_ERR: begin
        ctrl.load_err = 1'b1;
        state_d       = ST_MUL_PF;
      end
      ST_MUL_PF, ST_MUL_KP, ST_MUL_KI: begin
        ctrl.mul_step = 1'b1;
        step_d        = step_q + STEP_W'(1);
        if (step_q == STEP_LAST) begin
          step_d = '0;
          case (state_q)
            ST_MUL_PF: state_d = ST_INTEG;
            ST_MUL_KP: state_d = ST_PROP;
            default:   state_d = ST_EMIT;
          endcase
        end
      end
      ST_INTEG: begin
        ctrl.upd_integ = 1'b1;
        state_d        = ST_MUL_KP;
      end
      ST_PROP: begin
        ctrl.save_prop = 1'b1;
        state_d        = ST_MUL_KI;
      end
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  dwpi_chan #(.DRIVE_BITS(DRIVE_BITS)) u_top_chan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .target_i      (top_target_q),
    .count_i       (top_cnt_q),
    .period_frac_i (period_q),
    .prop_gain_i   (prop_gain_q),
    .integ_gain_i  (integ_gain_q),
    .lim_i         (lim),
    .drive_o       (top_drive),
    .small_o       (top_small)
  );

  dwpi_chan #(.DRIVE_BITS(DRIVE_BITS)) u_bot_chan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .target_i      (bot_target_q),
    .count_i       (bot_cnt_q),
    .period_frac_i (period_q),
    .prop_gain_i   (prop_gain_q),
    .integ_gain_i  (integ_gain_q),
    .lim_i         (lim),
    .drive_o       (bot_drive),
    .small_o       (bot_small)
  );

  // Output register; zero everything for a disabled request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (en_q) begin
        out_data_q <= OUT_W'({top_small && bot_small, bot_drive, top_drive});
      end else begin
        out_data_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  // An accepted request always leaves idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != ST_IDLE)
    else $error("sequencer stayed idle after accepting a request");

  // Step counter only runs inside the multiply phases
  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_MUL_PF && state_q != ST_MUL_KP && state_q != ST_MUL_KI)
      |-> step_q == '0)
    else $error("multiplier step counter nonzero outside multiply");

  // A disabled request yields an all-zero result
  a_disabled_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && !en_q |=> m_axis_tvalid && (m_axis_tdata == '0))
    else $error("disabled request produced nonzero result");

  // A result is never loaded over one that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q || m_axis_tready)
    else $error("result register overwritten while still pending");
`endif

endmodule

@@ dv/dwpi_regulator_checker.sv @@
module dwpi_regulator_checker
  import dwpi_pkg::*;
#(
  parameter int unsigned DRIVE_BITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [IDX_W-1:0]    cfg_idx_i,
  input  logic [CNT_W-1:0]    cfg_wdata_i,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [39:0]         s_axis_tdata,   // top_count, bottom_count, enable, zero fill
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [((2*DRIVE_BITS+1+7)/8)*8-1:0] m_axis_tdata,  // top_drive, bottom_drive,
                                                             // ready_res, zero fill
  output int                  pending_o,
  output int                  fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint INTEG_CAP   = 35 * 65536;  // 35.0 in Q8.16
  localparam longint NEAR_WINDOW = 5 * 256;     // 5 counts in .8
  localparam longint DRIVE_CAP   = (64'sd1 << DRIVE_BITS) - 1;

  typedef struct packed {
    logic [DRIVE_BITS-1:0] top_drive;
    logic [DRIVE_BITS-1:0] bottom_drive;
    logic                  ready_res;
  } drive_result_t;

  typedef struct packed {
    logic [DRIVE_BITS-1:0]      drive;
    logic                       near;
    logic signed [INTEG_W-1:0]  integ;
  } wheel_step_t;

  // Shadow of the register file and the two integrators
  logic [CNT_W-1:0]          top_target;
  logic [CNT_W-1:0]          bottom_target;
  logic [CNT_W-1:0]          prop_gain;
  logic [CNT_W-1:0]          integ_gain;
  logic [CNT_W-1:0]          period_frac;
  logic [MAXD_W-1:0]         max_drive;
  logic signed [INTEG_W-1:0] top_integ;
  logic signed [INTEG_W-1:0] bottom_integ;

  drive_result_t drive_q[$];
  int            mismatches;

  // One control period of one wheel: new integral, drive and near-target flag
  function automatic wheel_step_t wheel_update(input logic [CNT_W-1:0] target,
                                               input logic [CNT_W-1:0] count,
                                               input logic signed [INTEG_W-1:0] integ);
    wheel_step_t r;
    longint      err;
    longint      acc;
    longint      sum;
    longint      lim;
    longint      whole;
    err = longint'(target) - (longint'(count) << 8);
    acc = longint'(integ) + ((err * longint'(period_frac)) >>> 8);
    if (acc > INTEG_CAP) begin
      acc = INTEG_CAP;
    end else if (acc < -INTEG_CAP) begin
      acc = -INTEG_CAP;
    end
    r.integ = acc[INTEG_W-1:0];
    r.near  = (err < NEAR_WINDOW) && (err > -NEAR_WINDOW);
    sum     = err * longint'(prop_gain) + ((acc * longint'(integ_gain)) >>> 8);
    lim     = (longint'(max_drive) < DRIVE_CAP) ? longint'(max_drive) : DRIVE_CAP;
    whole   = sum >>> 16;
    // Reverse speed error or negative command: motor off
    if (err < 0 || sum <= 0) begin
      r.drive = '0;
    end else if (whole > lim) begin
      r.drive = lim[DRIVE_BITS-1:0];
    end else begin
      r.drive = whole[DRIVE_BITS-1:0];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    drive_result_t want;
    drive_result_t got;
    wheel_step_t   tw;
    wheel_step_t   bw;
    if (!rst_ni) begin
      top_target    = '0;
      bottom_target = '0;
      prop_gain     = 16'd256;
      integ_gain    = '0;
      period_frac   = 16'd655;
      max_drive     = 10'd1023;
      top_integ     = '0;
      bottom_integ  = '0;
      drive_q.delete();
      mismatches    = 0;
    end else begin
      // Mirror register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TOP_TARGET:    top_target    = cfg_wdata_i;
          REG_BOTTOM_TARGET: bottom_target = cfg_wdata_i;
          REG_PROP_GAIN:     prop_gain     = cfg_wdata_i;
          REG_INTEG_GAIN:    integ_gain    = cfg_wdata_i;
          REG_PERIOD_FRAC:   period_frac   = cfg_wdata_i;
          REG_MAX_DRIVE:     max_drive     = cfg_wdata_i[MAXD_W-1:0];
          default: ;
        endcase
      end

      // Compare each result against the oldest predicted drives
      if (m_axis_tvalid && m_axis_tready) begin
        got.top_drive    = m_axis_tdata[DRIVE_BITS-1:0];
        got.bottom_drive = m_axis_tdata[2*DRIVE_BITS-1:DRIVE_BITS];
        got.ready_res    = m_axis_tdata[2*DRIVE_BITS];
        if (drive_q.size() == 0) begin
          $error("unexpected result: tdata %h with no request outstanding", m_axis_tdata);
          mismatches++;
        end else begin
          want = drive_q.pop_front();
          if (got.top_drive !== want.top_drive) begin
            $error("top_drive: expected %0d, actual %0d", want.top_drive, got.top_drive);
            mismatches++;
          end
          if (got.bottom_drive !== want.bottom_drive) begin
            $error("bottom_drive: expected %0d, actual %0d",
                   want.bottom_drive, got.bottom_drive);
            mismatches++;
          end
          if (got.ready_res !== want.ready_res) begin
            $error("ready_res: expected %0d, actual %0d", want.ready_res, got.ready_res);
            mismatches++;
          end
        end
      end

      // Predict the drives for each accepted request
      if (s_axis_tvalid && s_axis_tready) begin
        if (!s_axis_tdata[32]) begin
          // Shut down: motors off, integrators hold
          want = '0;
        end else begin
          tw = wheel_update(top_target, s_axis_tdata[15:0], top_integ);
          bw = wheel_update(bottom_target, s_axis_tdata[31:16], bottom_integ);
          top_integ         = tw.integ;
          bottom_integ      = bw.integ;
          want.top_drive    = tw.drive;
          want.bottom_drive = bw.drive;
          want.ready_res    = tw.near && bw.near;
        end
        drive_q.push_back(want);
      end
    end
    pending_o    <= drive_q.size();
    fail_count_o <= mismatches;
  end

endmodule

@@ dv/dual_wheel_pi_speed_regulator_top_test.sv @@
module dual_wheel_pi_speed_regulator_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dwpi_pkg::*;

  localparam int unsigned DRIVE_BITS = 10;
  localparam int unsigned RES_W      = ((2 * DRIVE_BITS + 1 + 7) / 8) * 8;
  localparam int          STALL_LIMIT = 2000;
  localparam int          RANDOM_PHASES = 8;
  localparam int          PHASE_REQUESTS = 60;
  // Index with no register behind it
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i = '0;
  logic [CNT_W-1:0] cfg_wdata_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [39:0]      s_axis_tdata = '0;   // top_count, bottom_count, enable, zero fill
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [RES_W-1:0] m_axis_tdata;        // top_drive, bottom_drive, ready_res, zero fill

  int               pending;
  int               fail_count;
  int               quiet_cycles = 0;
  bit               idle_on = 1'b1;
  logic [CNT_W-1:0] top_goal = '0;
  logic [CNT_W-1:0] bottom_goal = '0;

  dual_wheel_pi_speed_regulator_top #(.DRIVE_BITS(DRIVE_BITS)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  dwpi_regulator_checker #(.DRIVE_BITS(DRIVE_BITS)) u_drive_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Stall the result side at random while idling is on
  always @(posedge clk_i) begin
    m_axis_tready <= !idle_on || ($urandom_range(99) >= 28);
  end

  // Abort when neither stream moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Send one control period, with an optional gap in front
  task automatic send_period(input logic [CNT_W-1:0] top_cnt,
                             input logic [CNT_W-1:0] bottom_cnt, input logic en);
    if (idle_on && $urandom_range(99) < 28) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(9) == 0) ? 70 : 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, en, bottom_cnt, top_cnt};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop valid and wait until every result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Hold write enable high across back-to-back writes; the caller drops it
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CNT_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [CNT_W-1:0] top_t, input logic [CNT_W-1:0] bot_t,
                               input logic [CNT_W-1:0] kp, input logic [CNT_W-1:0] ki,
                               input logic [CNT_W-1:0] pf, input logic [CNT_W-1:0] md);
    drain_results();
    write_reg(REG_TOP_TARGET, top_t);
    write_reg(REG_BOTTOM_TARGET, bot_t);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_PERIOD_FRAC, pf);
    write_reg(REG_MAX_DRIVE, md);
    if ($urandom_range(1)) write_reg(REG_UNUSED, 16'($urandom()));
    cfg_we_i    <= 1'b0;
    top_goal    = top_t;
    bottom_goal = bot_t;
  endtask

  // Mostly random, with the extremes now and then
  function automatic logic [CNT_W-1:0] pick_value(input int unsigned span);
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return CNT_W'($urandom_range(0, span));
      default: return CNT_W'($urandom());
    endcase
  endfunction

  // Counts near the target most of the time, anything otherwise
  function automatic logic [CNT_W-1:0] pick_count(input logic [CNT_W-1:0] goal);
    int near;
    near = int'(goal >> 8) + $urandom_range(0, 8) - 4;
    if ($urandom_range(3) == 0 || near < 0) return CNT_W'($urandom());
    return CNT_W'(near);
  endfunction

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: zero error, full reverse error driving the integral to its floor
    send_period(16'h0000, 16'h0000, 1'b1);
    send_period(16'hFFFF, 16'hFFFF, 1'b1);
    send_period(16'hFFFF, 16'hFFFF, 1'b1);
    send_period(16'h0000, 16'h0000, 1'b0);
    send_period(16'h0000, 16'h0000, 1'b1);

    // Top targets and gains: drive saturates, integral hits its ceiling
    load_settings(16'hFFFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_period(16'h0000, 16'h0000, 1'b1);
    send_period(16'h0000, 16'h0000, 1'b1);
    send_period(16'h00FF, 16'h0080, 1'b1);
    send_period(16'h00FF, 16'h0080, 1'b0);
    send_period(16'hAAAA, 16'h5555, 1'b1);

    // Negative command with positive error; ready window edge at five counts
    load_settings(16'h04FF, 16'h0500, 16'h0001, 16'hFFFF, 16'hFFFF, 16'd512);
    send_period(16'h00FF, 16'h00FF, 1'b1);
    send_period(16'h0000, 16'h0000, 1'b1);
    send_period(16'h0000, 16'h0001, 1'b1);

    // Negative side of the ready window; zero drive limit
    load_settings(16'h0001, 16'h0000, 16'h0100, 16'h0000, 16'h0001, 16'h0000);
    send_period(16'h0005, 16'h0000, 1'b1);
    send_period(16'h0005, 16'h0005, 1'b1);
    send_period(16'h0000, 16'h0000, 1'b1);

    // Drive limit below the field range
    load_settings(16'hFFFF, 16'hFFFF, 16'h00FF, 16'h0100, 16'h8000, 16'd100);
    send_period(16'h0000, 16'h0000, 1'b1);
    send_period(16'h007F, 16'h007F, 1'b1);

    // Random settings, one phase without any idling
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      idle_on = (phase != 3);
      load_settings(pick_value(16'hFFFF), pick_value(16'hFFFF), pick_value(16'h0400),
                    pick_value(16'h0400), pick_value(16'h1000), pick_value(16'h03FF));
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        send_period(pick_count(top_goal), pick_count(bottom_goal),
                    $urandom_range(99) < 85);
      end
    end
    idle_on = 1'b1;

    drain_results();
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
